/* rtl/ordered_multiset_with_rank_core_defines.svh */
`ifndef ORDERED_MULTISET_WITH_RANK_CORE_DEFINES_SVH
`define ORDERED_MULTISET_WITH_RANK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define OMSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("omsr check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define OMSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("omsr check failed");

`endif

/* rtl/omsr_pkg.sv */
package omsr_pkg;

	localparam int unsigned OMSR_CAPACITY = 256;
	localparam int unsigned KEY_W         = 32;
	localparam int unsigned POS_W         = 9;
	localparam int unsigned CNT_W         = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_RANK   = 2'd2,
		OP_SELECT = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic eval;
		logic ins;
		logic shl;
	} cell_ctl_t;

endpackage

/* rtl/omsr_enc.sv */
module omsr_enc #(
	parameter int unsigned N = 2,
	localparam int unsigned W = (N > 1) ? $clog2(N) : 1
) (
	input  logic [N-1:0] onehot,
	output logic [W-1:0] idx
);
	// or-tree encoder, input is one-hot or zero
	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (onehot[i]) begin
				idx = idx | W'(i);
			end
		end
	end

endmodule

/* rtl/omsr_cell.sv */
module omsr_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  omsr_pkg::cell_ctl_t                 ctl,
	input  logic signed [omsr_pkg::KEY_W-1:0]   opnd_key,
	input  logic        [omsr_pkg::POS_W-1:0]   opnd_pos,
	input  logic signed [omsr_pkg::KEY_W-1:0]   left_key,
	input  logic                                left_occ,
	input  logic                                left_less,
	input  logic signed [omsr_pkg::KEY_W-1:0]   right_key,
	input  logic                                right_occ,
	output logic signed [omsr_pkg::KEY_W-1:0]   key_q,
	output logic                                occ_q,
	output logic                                less_q,
	output logic                                eq_q,
	output logic                                hit_q
);
	import omsr_pkg::*;

	localparam int unsigned RANK = IDX + 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			less_q <= 1'b0;
			eq_q   <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (ctl.eval) begin
				less_q <= occ_q && (key_q < opnd_key);
				eq_q   <= occ_q && (key_q == opnd_key);
				hit_q  <= occ_q && (RANK == 32'(opnd_pos));
			end
			if (ctl.ins && !less_q) begin
				occ_q <= left_less ? 1'b1 : left_occ;
			end else if (ctl.shl && !less_q) begin
				occ_q <= right_occ;
			end
		end
	end

	// key storage, no reset
	always_ff @(posedge clk) begin
		if (ctl.ins && !less_q) begin
			key_q <= left_less ? opnd_key : left_key;
		end else if (ctl.shl && !less_q) begin
			key_q <= right_key;
		end
	end

endmodule

/* rtl/ordered_multiset_with_rank_core.sv */
// sequence: an accepted transaction passes the eval and scan states and then the resp state,
// where done rises; a delete that finds its key runs the shift state between scan and resp
// a new transaction is taken only in the idle state, once the last one is done; the
// delete loop moves the cell row by one place per cycle
// reset: held count and every cell occupancy bit clear at once, stored keys are left as is
// the receiver cannot stall: done is high for exactly one cycle, and the results stay until the next scan
module ordered_multiset_with_rank_core #(
	parameter int unsigned CAPACITY = omsr_pkg::OMSR_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic        [1:0]                 opcode,
	input  logic signed [omsr_pkg::KEY_W-1:0] key,
	input  logic        [omsr_pkg::POS_W-1:0] position,
	output logic                              done,
	output logic        [1:0]                 status,
	output logic signed [omsr_pkg::KEY_W-1:0] found_key,
	output logic        [omsr_pkg::CNT_W-1:0] found_rank,
	output logic        [omsr_pkg::CNT_W-1:0] removed,
	output logic        [omsr_pkg::CNT_W-1:0] count
);
	import omsr_pkg::*;

	// index width over the cell row and count width up to the full capacity
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	cell_ctl_t ctl;

	// operands of the transaction in flight
	opcode_t                 op_q;
	logic signed [KEY_W-1:0] key_q;
	logic        [POS_W-1:0] pos_q;

	// held count and delete loop counter
	logic [CW-1:0] count_q;
	logic [CW-1:0] shcnt_q;

	// result registers
	status_t                 status_q;
	logic signed [KEY_W-1:0] found_key_q;
	logic        [CW-1:0]    found_rank_q;
	logic        [CW-1:0]    removed_q;

	// cell row views
	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0] occ, less, eq, hit;
	logic [CAPACITY-1:0] first_eq, last_eq;

	// the row of cells; each one talks to its two neighbors only.
	// cell zero sees a "less" left side, so it takes the new key unless
	// it already holds a smaller one; the last cell pulls in an empty slot
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [KEY_W-1:0] lk, rk;
		logic lo, ll, ro;

		if (g == 0) begin : g_left_edge
			assign lk = '0;
			assign lo = 1'b0;
			assign ll = 1'b1;
		end else begin : g_left
			assign lk = cell_key[g-1];
			assign lo = occ[g-1];
			assign ll = less[g-1];
		end

		if (g == CAPACITY - 1) begin : g_right_edge
			assign rk = '0;
			assign ro = 1'b0;
		end else begin : g_right
			assign rk = cell_key[g+1];
			assign ro = occ[g+1];
		end

		omsr_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.opnd_key  (key_q),
			.opnd_pos  (pos_q),
			.left_key  (lk),
			.left_occ  (lo),
			.left_less (ll),
			.right_key (rk),
			.right_occ (ro),
			.key_q     (cell_key[g]),
			.occ_q     (occ[g]),
			.less_q    (less[g]),
			.eq_q      (eq[g]),
			.hit_q     (hit[g])
		);

		// equal keys form one contiguous run; mark both of its ends
		if (g == 0) begin : g_first0
			assign first_eq[g] = eq[g];
		end else begin : g_first
			assign first_eq[g] = eq[g] & ~eq[g-1];
		end
		if (g == CAPACITY - 1) begin : g_lastn
			assign last_eq[g] = eq[g];
		end else begin : g_last
			assign last_eq[g] = eq[g] & ~eq[g+1];
		end
	end

	// positions of the first and last copy of the key
	logic [IW-1:0] first_idx, last_idx;

	omsr_enc #(
		.N(CAPACITY)
	) u_enc_first (
		.onehot (first_eq),
		.idx    (first_idx)
	);

	omsr_enc #(
		.N(CAPACITY)
	) u_enc_last (
		.onehot (last_eq),
		.idx    (last_idx)
	);

	// at most one cell matches the asked rank, so an or-tree picks its key
	logic signed [KEY_W-1:0] sel_key;
	always_comb begin
		sel_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				sel_key = sel_key | cell_key[i];
			end
		end
	end

	logic          any_eq, any_hit, full;
	logic [CW-1:0] rank_val, rem_val;

	assign any_eq   = |eq;
	assign any_hit  = |hit;
	assign full     = (count_q == CW'(CAPACITY));
	assign rank_val = CW'(first_idx) + CW'(1);
	assign rem_val  = CW'(last_idx) - CW'(first_idx) + CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (op_q == OP_DELETE && any_eq) begin
					state_d = S_SHIFT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (shcnt_q == CW'(1)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// fsm outputs: cell commands and handshake
	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
			end
			S_EVAL: begin
				// every cell compares its key against the operands at once
				ctl.eval = 1'b1;
			end
			S_SCAN: begin
				// insert: cells at or above the lower bound move up one place
				ctl.ins = (op_q == OP_INSERT) && !full;
			end
			S_SHIFT: begin
				// delete: cells at or above the lower bound move down one place
				ctl.shl = 1'b1;
			end
			S_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			shcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN) begin
				if (ctl.ins) begin
					count_q <= count_q + CW'(1);
				end
				shcnt_q <= rem_val;
			end
			if (state_q == S_SHIFT) begin
				shcnt_q <= shcnt_q - CW'(1);
				if (shcnt_q == CW'(1)) begin
					count_q <= count_q - removed_q;
				end
			end
		end
	end

	// operand capture and result formation
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= opcode_t'(opcode);
			key_q <= key;
			pos_q <= position;
		end
		if (state_q == S_SCAN) begin
			status_q     <= STS_OK;
			found_key_q  <= '0;
			found_rank_q <= '0;
			removed_q    <= '0;
			case (op_q)
				OP_INSERT: begin
					if (full) begin
						status_q <= STS_FULL;
					end
				end
				OP_DELETE: begin
					if (any_eq) begin
						removed_q <= rem_val;
					end else begin
						status_q <= STS_NOT_FOUND;
					end
				end
				OP_RANK: begin
					if (any_eq) begin
						found_rank_q <= rank_val;
					end else begin
						status_q <= STS_NOT_FOUND;
					end
				end
				OP_SELECT: begin
					if (any_hit) begin
						found_key_q <= sel_key;
					end else begin
						status_q <= STS_RANGE;
					end
				end
				default: begin
					status_q <= STS_OK;
				end
			endcase
		end
	end

	// result ports; counts are shown in their low bits
	assign status     = status_q;
	assign found_key  = found_key_q;
	assign found_rank = CNT_W'(found_rank_q);
	assign removed    = CNT_W'(removed_q);
	assign count      = CNT_W'(count_q);

endmodule

/* rtl/omsr_chk.sv */
`include "ordered_multiset_with_rank_core_defines.svh"

module omsr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic        [1:0]                 status,
	input logic signed [omsr_pkg::KEY_W-1:0] found_key,
	input logic        [omsr_pkg::CNT_W-1:0] found_rank,
	input logic        [omsr_pkg::CNT_W-1:0] removed
);
	import omsr_pkg::*;

	// a result only comes out of a transaction in flight
	`OMSR_ASSERT_NOW(a_done_while_busy, done, busy)
	// an accepted transaction holds the block: eval follows, busy and without done
	`OMSR_ASSERT_NEXT(a_accept_holds, start && !busy, busy && !done)
	// one strobe per transaction
	`OMSR_ASSERT_NEXT(a_done_single, done, !done)
	// a failed transaction reports nothing but its status and count
	`OMSR_ASSERT_NOW(a_fail_zero, done && (status != STS_OK), (removed == '0) && (found_rank == '0) && (found_key == '0))

endmodule

bind ordered_multiset_with_rank_core omsr_chk u_omsr_chk (.*);
